// ===== hdl/sbcm_pkg.sv =====
// shared types, constants and helpers for the sprite blitter
// no dependencies

package sbcm_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 256;
	localparam logic [7:0] TRANSPARENT_ALPHA = 8'd0;

	// signed coordinate before clipping: dest (11b signed) - origin (8b) + offset (9b signed)
	localparam int SX_W   = 13;
	// on-screen coordinate, screen dimensions are at most 1024
	localparam int COORD_W = 10;
	localparam int PROD_W = 21;
	localparam int ADDR_W = 16;

	typedef enum logic [2:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_ORIGIN_X      = 3'd2,
		REG_ORIGIN_Y      = 3'd3,
		REG_SPRITE_WIDTH  = 3'd4,
		REG_SPRITE_HEIGHT = 3'd5,
		REG_MIRROR_X      = 3'd6,
		REG_MIRROR_Y      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [10:0] dest_x;
		logic signed [10:0] dest_y;
		logic [7:0]         origin_x;
		logic [7:0]         origin_y;
		logic [8:0]         sprite_width;
		logic [8:0]         sprite_height;
		logic               mirror_x;
		logic               mirror_y;
	} cfg_t;

	// position of the current pixel inside the sprite after mirroring
	typedef struct packed {
		logic signed [8:0] dc;
		logic signed [8:0] dr;
		logic              last;
	} pos_t;

	// size minus one, with zero acting as one and anything above 256 as 256
	function automatic logic [7:0] size_m1(logic [8:0] size);
		logic [8:0] d;
		d = size - 9'd1;
		if (size == 9'd0)
			return 8'd0;
		else if (size > 9'd256)
			return 8'd255;
		else
			return d[7:0];
	endfunction

endpackage

// ===== hdl/sprite_blit_clip_mirror.sv =====
// sprite blitter top level: config registers, input stage, clip and address stage
// depends on sbcm_pkg and sbcm_raster
// an accepted input word is registered in the input stage, then in the output stage
// throughput: one word per cycle while the output is not blocked; the counter compare
// at input and the address multiply-add at output set the cycle
// reset: counters clear, pipeline empties, config returns to origin 0, size 8x8, no mirror

module sprite_blit_clip_mirror import sbcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// source pixels
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // red, green, blue, alpha
	// framebuffer write requests
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // pixel_address, out_red, out_green, out_blue, out_alpha
	output logic        m_axis_tuser,  // write_enable
	output logic        m_axis_tlast   // last
);

	cfg_t  cfg_q;
	pos_t  pos;

	logic        valid_s1;
	logic [31:0] pix_s1;
	pos_t        pos_s1;

	logic        valid_s2;
	logic [47:0] data_s2;
	logic        we_s2;
	logic        last_s2;

	logic        advance;
	logic        accept;

	logic signed [SX_W-1:0] sx;
	logic signed [SX_W-1:0] sy;
	logic                   on_screen;
	logic [PROD_W-1:0]      addr_full;
	logic [ADDR_W-1:0]      addr;
	logic                   we;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x        <= 11'sd0;
			cfg_q.dest_y        <= 11'sd0;
			cfg_q.origin_x      <= 8'd0;
			cfg_q.origin_y      <= 8'd0;
			cfg_q.sprite_width  <= 9'd8;
			cfg_q.sprite_height <= 9'd8;
			cfg_q.mirror_x      <= 1'b0;
			cfg_q.mirror_y      <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_DEST_X:        cfg_q.dest_x        <= $signed(cfg_data);
				REG_DEST_Y:        cfg_q.dest_y        <= $signed(cfg_data);
				REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data[7:0];
				REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data[7:0];
				REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[8:0];
				REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[8:0];
				REG_MIRROR_X:      cfg_q.mirror_x      <= cfg_data[0];
				REG_MIRROR_Y:      cfg_q.mirror_y      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the output stage moves when empty or taken; the input stage fills behind it
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = advance || !valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	sbcm_raster u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cfg    (cfg_q),
		.pos    (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= s_axis_tdata;
			pos_s1 <= pos;
		end
	end

	// screen coordinate, clip and framebuffer address
	always_comb begin
		sx = SX_W'(cfg_q.dest_x) - $signed({{(SX_W-8){1'b0}}, cfg_q.origin_x}) + SX_W'(pos_s1.dc);
		sy = SX_W'(cfg_q.dest_y) - $signed({{(SX_W-8){1'b0}}, cfg_q.origin_y}) + SX_W'(pos_s1.dr);
		on_screen = !sx[SX_W-1] && !sy[SX_W-1]
			&& ($unsigned(sx) < SX_W'(SCREEN_WIDTH))
			&& ($unsigned(sy) < SX_W'(SCREEN_HEIGHT));
		addr_full = PROD_W'(sy[COORD_W-1:0]) * PROD_W'(SCREEN_WIDTH)
			+ PROD_W'(sx[COORD_W-1:0]);
		addr = on_screen ? addr_full[ADDR_W-1:0] : '0;
		we   = on_screen && (pix_s1[31:24] != TRANSPARENT_ALPHA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2 <= {pix_s1, addr};
			we_s2   <= we;
			last_s2 <= pos_s1.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = we_s2;
	assign m_axis_tlast  = last_s2;

	// input only stalls when both stages hold words and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// a word in the input stage always reaches the output the cycle after it moves
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_axis_tvalid)
		else $error("word lost between stages");

	// an enabled write never carries a keyed-out pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:40] != TRANSPARENT_ALPHA))
		else $error("transparent pixel written");

endmodule

// ===== hdl/sbcm_raster.sv =====
// row and column counters that track each pixel's place in the sprite
// depends on sbcm_pkg

module sbcm_raster import sbcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cfg_t cfg,
	output pos_t pos
);

	logic [7:0] col_q;
	logic [7:0] row_q;
	logic [7:0] wm1;
	logic [7:0] hm1;
	logic       end_row;
	logic       end_all;

	assign wm1 = size_m1(cfg.sprite_width);
	assign hm1 = size_m1(cfg.sprite_height);

	// a count at or past the last column also ends the row, in case the size shrank
	assign end_row = col_q >= wm1;
	assign end_all = end_row && (row_q >= hm1);

	always_comb begin
		if (cfg.mirror_x)
			pos.dc = $signed({1'b0, wm1}) - $signed({1'b0, col_q});
		else
			pos.dc = $signed({1'b0, col_q});
		if (cfg.mirror_y)
			pos.dr = $signed({1'b0, hm1}) - $signed({1'b0, row_q});
		else
			pos.dr = $signed({1'b0, row_q});
		pos.last = end_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 8'd0;
			row_q <= 8'd0;
		end else if (step) begin
			if (end_all) begin
				col_q <= 8'd0;
				row_q <= 8'd0;
			end else if (end_row) begin
				col_q <= 8'd0;
				row_q <= row_q + 8'd1;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

endmodule

// ===== tb/tb_sprite_blit_clip_mirror.sv =====
// self-checking testbench for the sprite blitter: queue-fed pixel and register drivers,
// a clocked monitor with its own blit predictor, random idling and back-pressure phases
// depends on sbcm_pkg and sprite_blit_clip_mirror

module tb_sprite_blit_clip_mirror;
	import sbcm_pkg::*;

	typedef struct packed {
		logic       we;
		logic [15:0] addr;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} fb_write_t;

	typedef struct packed {
		reg_idx_t    idx;
		logic [10:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // red, green, blue, alpha
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;  // pixel_address, out_red, out_green, out_blue, out_alpha
	logic        m_axis_tuser;  // write_enable
	logic        m_axis_tlast;  // last

	sprite_blit_clip_mirror i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pending stimulus and expected framebuffer writes
	logic [31:0] pixel_q[$];
	reg_write_t  reg_q[$];
	fb_write_t   fb_write_q[$];

	// predictor copy of the registers and the raster counters
	cfg_t       shadow;
	logic [7:0] row_cnt;
	logic [7:0] col_cnt;

	logic pixel_taken = 1'b0;
	logic reg_taken = 1'b0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   rx_hold_req = 0;
	int   rx_hold_seen = 0;

	int errors = 0;
	int words_checked = 0;
	int writes_enabled = 0;
	int sprite_ends = 0;
	int pixels_pushed = 0;
	int settings_used = 0;
	fb_write_t exp_w;

	function automatic int eff_size(logic [8:0] raw);
		if (raw == 9'd0)
			return 1;
		else if (raw > 9'd256)
			return 256;
		else
			return raw;
	endfunction

	function automatic fb_write_t blit_predict(logic [31:0] px);
		int w, h, col, row, dc, dr, sx, sy, lin;
		logic on, end_row, end_all;
		fb_write_t res;
		w = eff_size(shadow.sprite_width);
		h = eff_size(shadow.sprite_height);
		col = col_cnt;
		row = row_cnt;
		dc = shadow.mirror_x ? (w - 1 - col) : col;
		dr = shadow.mirror_y ? (h - 1 - row) : row;
		sx = int'(shadow.dest_x[9:0]) - (shadow.dest_x[10] ? 1024 : 0)
			- int'(shadow.origin_x) + dc;
		sy = int'(shadow.dest_y[9:0]) - (shadow.dest_y[10] ? 1024 : 0)
			- int'(shadow.origin_y) + dr;
		on = sx >= 0 && sx < SCREEN_WIDTH && sy >= 0 && sy < SCREEN_HEIGHT;
		lin = sy * SCREEN_WIDTH + sx;
		// a row ends at the last column or beyond it, after a size shrink
		end_row = col >= w - 1;
		end_all = end_row && row >= h - 1;
		res.we = on && px[31:24] != TRANSPARENT_ALPHA;
		res.addr = on ? lin[15:0] : 16'd0;
		res.red = px[7:0];
		res.green = px[15:8];
		res.blue = px[23:16];
		res.alpha = px[31:24];
		res.last = end_all;
		if (end_all) begin
			col_cnt = 8'd0;
			row_cnt = 8'd0;
		end else if (end_row) begin
			col_cnt = 8'd0;
			row_cnt = row_cnt + 8'd1;
		end else begin
			col_cnt = col_cnt + 8'd1;
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// register words
	always @(negedge clk) begin
		if (!cfg_valid || reg_taken) begin
			if (reg_q.size() != 0) begin
				cfg_valid <= 1'b1;
				cfg_index <= reg_q[0].idx;
				cfg_data <= reg_q[0].data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// source pixel words
	always @(negedge clk) begin
		if (!s_axis_tvalid || pixel_taken) begin
			if (pixel_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pixel_q[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off counted here on request
	always @(negedge clk) begin
		if (rx_hold_seen < rx_hold_req) begin
			m_axis_tready <= 1'b0;
			rx_hold_seen <= rx_hold_seen + 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		reg_taken <= cfg_valid && cfg_ready;
		pixel_taken <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			if (fb_write_q.size() == 0) begin
				$display("%0t: unexpected write word, expected none got addr %h we %b",
					$time, m_axis_tdata[15:0], m_axis_tuser);
				errors++;
			end else begin
				exp_w = fb_write_q.pop_front();
				check_field("write_enable", exp_w.we, m_axis_tuser);
				check_field("pixel_address", exp_w.addr, m_axis_tdata[15:0]);
				check_field("out_red", exp_w.red, m_axis_tdata[23:16]);
				check_field("out_green", exp_w.green, m_axis_tdata[31:24]);
				check_field("out_blue", exp_w.blue, m_axis_tdata[39:32]);
				check_field("out_alpha", exp_w.alpha, m_axis_tdata[47:40]);
				check_field("last", exp_w.last, m_axis_tlast);
				words_checked++;
				if (exp_w.we)
					writes_enabled++;
				if (exp_w.last)
					sprite_ends++;
			end
		end
		if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_DEST_X:        shadow.dest_x = cfg_data;
				REG_DEST_Y:        shadow.dest_y = cfg_data;
				REG_ORIGIN_X:      shadow.origin_x = cfg_data[7:0];
				REG_ORIGIN_Y:      shadow.origin_y = cfg_data[7:0];
				REG_SPRITE_WIDTH:  shadow.sprite_width = cfg_data[8:0];
				REG_SPRITE_HEIGHT: shadow.sprite_height = cfg_data[8:0];
				REG_MIRROR_X:      shadow.mirror_x = cfg_data[0];
				REG_MIRROR_Y:      shadow.mirror_y = cfg_data[0];
				default: ;
			endcase
			void'(reg_q.pop_front());
		end
		if (s_axis_tvalid && s_axis_tready) begin
			fb_write_q.insert(fb_write_q.size(), blit_predict(s_axis_tdata));
			void'(pixel_q.pop_front());
		end
	end

	task automatic push_pixel(input logic [31:0] px);
		pixel_q.insert(pixel_q.size(), px);
		pixels_pushed++;
	endtask

	task automatic push_random_pixel();
		logic [31:0] px;
		px = $urandom;
		// colour key hit now and then
		if ($urandom_range(0, 4) == 0)
			px[31:24] = TRANSPARENT_ALPHA;
		push_pixel(px);
	endtask

	task automatic queue_reg(input reg_idx_t idx, input logic [10:0] data);
		reg_write_t rw;
		rw.idx = idx;
		rw.data = data;
		reg_q.insert(reg_q.size(), rw);
	endtask

	task automatic wait_drained();
		while (pixel_q.size() != 0 || fb_write_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// unused upper bits of the narrow registers carry junk
	task automatic set_regs(input int dx, input int dy, input int ox, input int oy,
			input int w, input int h, input int mx, input int my);
		logic [10:0] junk;
		logic [10:0] v;
		junk = 11'($urandom);
		v = 11'(dx);
		queue_reg(REG_DEST_X, v);
		v = 11'(dy);
		queue_reg(REG_DEST_Y, v);
		v = 11'(ox);
		queue_reg(REG_ORIGIN_X, {junk[10:8], v[7:0]});
		v = 11'(oy);
		queue_reg(REG_ORIGIN_Y, {junk[2:0], v[7:0]});
		v = 11'(w);
		queue_reg(REG_SPRITE_WIDTH, {junk[4:3], v[8:0]});
		v = 11'(h);
		queue_reg(REG_SPRITE_HEIGHT, {junk[6:5], v[8:0]});
		v = 11'(mx);
		queue_reg(REG_MIRROR_X, {junk[10:1], v[0]});
		v = 11'(my);
		queue_reg(REG_MIRROR_Y, {junk[9:0], v[0]});
		while (reg_q.size() != 0)
			@(posedge clk);
		settings_used++;
	endtask

	initial begin
		#2000000;
		$display("timeout: write words still outstanding");
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int phase_no, w_raw, h_raw, n, k, dx, dy, ox, oy;
		shadow.dest_x = '0;
		shadow.dest_y = '0;
		shadow.origin_x = '0;
		shadow.origin_y = '0;
		shadow.sprite_width = 9'd8;
		shadow.sprite_height = 9'd8;
		shadow.mirror_x = 1'b0;
		shadow.mirror_y = 1'b0;
		row_cnt = '0;
		col_cnt = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, extremes of the colour fields, keyed and opaque
		push_pixel(32'h0000_0000);
		push_pixel(32'hFFFF_FFFF);
		push_pixel(32'h00FF_FFFF);
		push_pixel(32'hFF00_0000);
		wait_drained();
		// width shrinks under a counter that is past it, mirrored at the screen corner
		set_regs(255, 255, 0, 0, 3, 1, 1, 0);
		repeat (4) push_random_pixel();
		wait_drained();
		// zero sizes act as one, far off screen
		set_regs(-1024, 1023, 0, 0, 0, 0, 0, 1);
		push_pixel(32'h8012_3456);
		push_pixel(32'h0165_4321);
		wait_drained();
		// oversize acts as 256, both mirrors, last screen pixel
		set_regs(255, 255, 255, 255, 511, 511, 1, 1);
		repeat (3) push_random_pixel();
		wait_drained();
		// small mirrored sprite on screen with a transparent pixel
		set_regs(10, 20, 1, 1, 2, 2, 1, 1);
		push_pixel(32'h7F10_2030);
		push_pixel(32'h0012_3456);
		push_pixel(32'h01AB_CDEF);
		push_pixel(32'hFE55_AA55);
		wait_drained();

		phase_no = 0;
		while (pixels_pushed < 820) begin
			wait_drained();
			if (phase_no == 5) begin
				w_raw = $urandom_range(256, 511);
				h_raw = $urandom_range(0, 1);
			end else if (phase_no == 11) begin
				w_raw = $urandom_range(0, 1);
				h_raw = $urandom_range(256, 511);
			end else begin
				w_raw = $urandom_range(0, 12);
				h_raw = $urandom_range(0, 12);
			end
			// mostly near the screen edges so clipping bites
			dx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) - 1024
				: $urandom_range(0, 300) - 30;
			dy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) - 1024
				: $urandom_range(0, 300) - 30;
			ox = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
			oy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
			set_regs(dx, dy, ox, oy, w_raw, h_raw, $urandom_range(0, 1), $urandom_range(0, 1));
			case (phase_no % 4)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				1: begin
					tx_idle_pct = 74;
					rx_idle_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 74;
				end
				default: begin
					tx_idle_pct = 8;
					rx_idle_pct = 8;
				end
			endcase
			if (phase_no == 2 || phase_no == 9) begin
				// receiver holds off while the sender keeps the input full
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				rx_hold_req = rx_hold_req + 300;
				repeat (40) push_random_pixel();
			end
			for (k = $urandom_range(1, 3); k > 0 && pixels_pushed < 820; k--) begin
				n = eff_size(9'(w_raw)) * eff_size(9'(h_raw));
				// a cut-short sprite leaves the counters mid raster
				if (n > 1 && $urandom_range(0, 9) == 0)
					n = $urandom_range(1, n - 1);
				// keep the run near its intended length
				if (n > 820 - pixels_pushed)
					n = 820 - pixels_pushed;
				repeat (n) push_random_pixel();
				if ($urandom_range(0, 6) == 0)
					wait_drained();
			end
			phase_no++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("blitted %0d pixels under %0d register settings, %0d words checked",
			pixels_pushed, settings_used, words_checked);
		$display("%0d writes enabled, %0d clipped or keyed, %0d sprite ends",
			writes_enabled, words_checked - writes_enabled, sprite_ends);
		if (errors == 0 && fb_write_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
